// File: hdl/bmhq_pkg.sv
// ============================================================================
// bmhq_pkg
// Shared constants and types for the binary min-heap priority queue.
// ============================================================================
package bmhq_pkg;

    // Default sizing of the queue.
    localparam int HEAP_DEPTH_DEF   = 1024;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 64;

    // Fixed widths of the transaction fields on the ports.
    localparam int KEY_PORT_W     = 32;
    localparam int PAYLOAD_PORT_W = 64;
    localparam int STATUS_W       = 2;
    localparam int TOTAL_W        = 11;

    typedef logic [STATUS_W-1:0] t_status;

    // Command codes.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes.
    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

endpackage

// File: hdl/binary_min_heap_queue_top.sv
// ============================================================================
// binary_min_heap_queue_top
// Binary min-heap priority queue keyed by an unsigned cost, with a payload
// carried alongside each key, held in one RAM and sifted one level at a time.
// ============================================================================
//
//  Channel   Handshake                 Fields
//  --------  ------------------------  ---------------------------------------
//  command   start (in) / busy (out)   i_command, i_sort_key, i_entry_payload
//  result    o_result_valid (strobe)   o_popped_key, o_popped_payload,
//                                      o_status, o_entry_total
//
//  A transaction is taken when start is high and busy is low; its result is
//  strobed for one cycle once the sift has finished, with busy low again.
//  Push climbs one level at a time, comparing the entry with its parent. Pop
//  reads the root and the last entry, then descends; a level with two children
//  takes two RAM reads and two key compares. Failed operations and a push
//  into an empty queue report in the cycle after acceptance, a pop of the last
//  entry once the root has been read. Reset clears the control state and the
//  entry count, not the RAM. The receiver cannot stall the result.
// ============================================================================
module binary_min_heap_queue_top #(
    parameter int HEAP_DEPTH   = bmhq_pkg::HEAP_DEPTH_DEF,
    parameter int KEY_BITS     = bmhq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = bmhq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_command,
    input  logic [bmhq_pkg::KEY_PORT_W-1:0]     i_sort_key,
    input  logic [bmhq_pkg::PAYLOAD_PORT_W-1:0] i_entry_payload,
    output logic                                o_result_valid,
    output logic [bmhq_pkg::KEY_PORT_W-1:0]     o_popped_key,
    output logic [bmhq_pkg::PAYLOAD_PORT_W-1:0] o_popped_payload,
    output bmhq_pkg::t_status                   o_status,
    output logic [bmhq_pkg::TOTAL_W-1:0]        o_entry_total
);
    import bmhq_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int LW = AW + 1;
    localparam int DW = KEY_BITS + PAYLOAD_BITS;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_UP_CMP    = 3'd1;
    localparam logic [2:0] S_PLACE     = 3'd2;
    localparam logic [2:0] S_POP_ROOT  = 3'd3;
    localparam logic [2:0] S_POP_LAST  = 3'd4;
    localparam logic [2:0] S_DN_ISSUE  = 3'd5;
    localparam logic [2:0] S_DN_LWAIT  = 3'd6;
    localparam logic [2:0] S_DN_RCMP   = 3'd7;

    logic [2:0]                r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [AW-1:0]             r_pos, n_pos;
    logic [KEY_BITS-1:0]       r_x_key, n_x_key;
    logic [PAYLOAD_BITS-1:0]   r_x_pay, n_x_pay;
    logic [KEY_BITS-1:0]       r_best_key, n_best_key;
    logic [PAYLOAD_BITS-1:0]   r_best_pay, n_best_pay;
    logic [AW-1:0]             r_best_idx, n_best_idx;
    logic                      r_best_child, n_best_child;
    logic                      r_valid, n_valid;
    logic [KEY_PORT_W-1:0]     r_okey, n_okey;
    logic [PAYLOAD_PORT_W-1:0] r_opay, n_opay;
    t_status                   r_status, n_status;

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [DW-1:0]             wr_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [DW-1:0]             rd_data;
    logic [KEY_BITS-1:0]       rd_key;
    logic [PAYLOAD_BITS-1:0]   rd_pay;

    logic [KEY_BITS-1:0]       cmp_a;
    logic [KEY_BITS-1:0]       cmp_b;
    logic                      lt;

    logic [KEY_BITS-1:0]       in_key;
    logic [PAYLOAD_BITS-1:0]   in_pay;
    logic [AW-1:0]             tail_idx;
    logic [AW-1:0]             tail_parent;
    logic [AW-1:0]             up_idx;
    logic [AW-1:0]             up_parent;
    logic [LW-1:0]             lc;
    logic [LW-1:0]             rc;
    logic [LW-1:0]             count_ext;

    bmhq_ram #(
        .WIDTH (DW),
        .DEPTH (HEAP_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_key = rd_data[DW-1 -: KEY_BITS];
    assign rd_pay = rd_data[PAYLOAD_BITS-1:0];

    assign in_key = KEY_BITS'(i_sort_key);
    assign in_pay = PAYLOAD_BITS'(i_entry_payload);

    // Index arithmetic for the climb and the descent.
    assign tail_idx    = AW'(r_count);
    assign tail_parent = AW'((tail_idx - 1'b1) >> 1);
    assign up_idx      = AW'((r_pos - 1'b1) >> 1);
    assign up_parent   = AW'((up_idx - 1'b1) >> 1);
    assign lc          = {r_pos, 1'b1};
    assign rc          = LW'(lc + 1'b1);
    assign count_ext   = LW'(r_count);

    // The one key comparator shared by every step of both sifts.
    assign lt = (cmp_a < cmp_b);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_x_key      = r_x_key;
        n_x_pay      = r_x_pay;
        n_best_key   = r_best_key;
        n_best_pay   = r_best_pay;
        n_best_idx   = r_best_idx;
        n_best_child = r_best_child;
        n_valid      = 1'b0;
        n_okey       = r_okey;
        n_opay       = r_opay;
        n_status     = r_status;
        wr_en        = 1'b0;
        wr_addr      = r_pos;
        wr_data      = {r_x_key, r_x_pay};
        rd_en        = 1'b0;
        rd_addr      = up_parent;
        cmp_a        = r_x_key;
        cmp_b        = rd_key;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_x_key  = in_key;
                    n_x_pay  = in_pay;
                    n_okey   = '0;
                    n_opay   = '0;
                    n_status = ST_DONE;
                    if (i_command == CMD_PUSH) begin
                        if (r_count == CW'(HEAP_DEPTH)) begin
                            n_status = ST_FULL;
                            n_valid  = 1'b1;
                        end else begin
                            n_count = CW'(r_count + 1'b1);
                            n_pos   = tail_idx;
                            if (r_count == '0) begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = {in_key, in_pay};
                                n_valid = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = tail_parent;
                                n_state = S_UP_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_valid  = 1'b1;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = S_POP_ROOT;
                        end
                    end
                end
            end
            S_UP_CMP: begin
                // The parent sits in the read register; move it down if the
                // new entry is strictly smaller.
                cmp_a = r_x_key;
                cmp_b = rd_key;
                if (lt) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos;
                    wr_data = rd_data;
                    n_pos   = up_idx;
                    if (up_idx == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = up_parent;
                    end
                end else begin
                    wr_en   = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PLACE: begin
                wr_en   = 1'b1;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_POP_ROOT: begin
                n_okey  = KEY_PORT_W'(rd_key);
                n_opay  = PAYLOAD_PORT_W'(rd_pay);
                n_count = CW'(r_count - 1'b1);
                if (r_count == CW'(1)) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_count - 1'b1);
                    n_state = S_POP_LAST;
                end
            end
            S_POP_LAST: begin
                n_x_key = rd_key;
                n_x_pay = rd_pay;
                n_pos   = '0;
                n_state = S_DN_ISSUE;
            end
            S_DN_ISSUE: begin
                if (lc >= count_ext) begin
                    wr_en   = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(lc);
                    n_state = S_DN_LWAIT;
                end
            end
            S_DN_LWAIT: begin
                cmp_a = rd_key;
                cmp_b = r_x_key;
                if (rc < count_ext) begin
                    // Remember the left child and whether it is smaller than the
                    // moving entry, then fetch the right child.
                    n_best_child = lt;
                    n_best_key   = rd_key;
                    n_best_pay   = rd_pay;
                    n_best_idx   = AW'(lc);
                    rd_en        = 1'b1;
                    rd_addr      = AW'(rc);
                    n_state      = S_DN_RCMP;
                end else if (lt) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    n_pos   = AW'(lc);
                    n_state = S_DN_ISSUE;
                end else begin
                    wr_en   = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DN_RCMP: begin
                cmp_a = rd_key;
                cmp_b = r_best_child ? r_best_key : r_x_key;
                if (lt) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    n_pos   = AW'(rc);
                    n_state = S_DN_ISSUE;
                end else if (r_best_child) begin
                    wr_en   = 1'b1;
                    wr_data = {r_best_key, r_best_pay};
                    n_pos   = r_best_idx;
                    n_state = S_DN_ISSUE;
                end else begin
                    wr_en   = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_x_key      <= n_x_key;
        r_x_pay      <= n_x_pay;
        r_best_key   <= n_best_key;
        r_best_pay   <= n_best_pay;
        r_best_idx   <= n_best_idx;
        r_best_child <= n_best_child;
        r_okey       <= n_okey;
        r_opay       <= n_opay;
        r_status     <= n_status;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_result_valid   = r_valid;
    assign o_popped_key     = r_okey;
    assign o_popped_payload = r_opay;
    assign o_status         = r_status;
    // The count is final by the time the result is strobed.
    assign o_entry_total    = TOTAL_W'(r_count);

    // A full report must come from a queue that really is full.
    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_FULL) |-> (r_count == CW'(HEAP_DEPTH)))
        else $error("full status reported with room left in the queue");

    // An empty report must come from a queue that really is empty.
    a_empty_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status reported with entries held");

    // Every sift works on a queue that holds at least one entry.
    a_sift_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_count != '0))
        else $error("sift in progress on an empty queue");

    // An accepted transaction either starts a sift or reports at once.
    a_accept_progress : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || r_valid))
        else $error("accepted transaction neither started nor reported");

    // The count never grows past the storage.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count <= CW'(HEAP_DEPTH)))
        else $error("entry count exceeds the queue depth");

endmodule

// File: hdl/bmhq_ram.sv
// ============================================================================
// bmhq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module bmhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
